@@ design/dsten_pkg.sv @@
`timescale 1ns / 1ps

package dsten_pkg;

  // Command codes on func
  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_STEP  = 2'd2;

  // Configuration register indexes
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;
  localparam logic [CFG_INDEX_W-1:0] REG_BC_MODE     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LEFT_TERM   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_RIGHT_TERM  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_COEFF       = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_GRID_POINTS = 3'd4;

  // Field widths
  localparam int TERM_W  = 32;
  localparam int COEFF_W = 16;
  localparam int GRID_W  = 9;
  localparam int INDEX_W = 8;
  localparam int STEPS_W = 16;
  localparam logic [GRID_W-1:0] GRID_RESET = 9'd256;

  // Boundary modes
  localparam logic BC_NEUMANN   = 1'b0;
  localparam logic BC_DIRICHLET = 1'b1;

  // Status from the stencil unit to the sequencer
  typedef struct packed {
    logic wr_valid;  // result word on wdata, write it this cycle
    logic busy;      // any stage still holds a point
  } unit_stat_t;

endpackage

@@ design/diffusion_stencil_1d_top.sv @@
`timescale 1ns / 1ps

// 1D explicit diffusion engine over a grid of signed fixed-point points held
// in a single RAM. After reset the RAM is swept to zero with busy high. A write
// or read (func 0/1) passes S_EXEC, and a read with a valid index also S_RWAIT,
// before done. In an advance (func 2), each step reads the two ends for the
// ghost values, then streams one point per cycle through the shared stencil
// unit (a 4-stage subtract / multiply / round / clamp pipe) and drains it
// before the next step. Every command gives exactly one done pulse of one
// cycle; the receiver cannot stall it, so read_value and status must be
// taken in that cycle. Configuration must be written only while busy is low
// and no result is pending; this binds the user, the block does not enforce it.
module diffusion_stencil_1d_top
  import dsten_pkg::*;
#(
  parameter int GRID_DEPTH  = 256,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               func,
  input  logic [INDEX_W-1:0]       point_index,
  input  logic signed [31:0]       point_value,
  input  logic [STEPS_W-1:0]       step_count,
  output logic                     done,
  output logic signed [31:0]       read_value,
  output logic                     status,
  input  logic                     cfg_write,
  input  logic [CFG_INDEX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data
);

  localparam int VW = VALUE_WIDTH;
  localparam int AW = $clog2(GRID_DEPTH);
  localparam int NW = $clog2(GRID_DEPTH + 1);
  localparam int CW = (NW > GRID_W) ? NW : GRID_W;
  localparam int GW = ((VW > 32) ? VW : 32) + 1;
  localparam int EW = (VW > 32) ? VW : 32;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_EXEC, S_RWAIT, S_GH0, S_GH1, S_GH2, S_SWEEP, S_DRAIN
  } state_t;

  state_t state;

  // Configuration registers
  logic                      bc_mode;
  logic signed [TERM_W-1:0]  left_term;
  logic signed [TERM_W-1:0]  right_term;
  logic [COEFF_W-1:0]        coeff;
  logic [GRID_W-1:0]         grid_points;

  // Command and sweep registers
  logic [1:0]           func_q;
  logic [INDEX_W-1:0]   idx_q;
  logic signed [31:0]   val_q;
  logic [STEPS_W-1:0]   steps_left;
  logic [NW-1:0]        rd_ptr;
  logic [AW-1:0]        wr_ptr;
  logic [AW-1:0]        clr_ptr;
  logic                 pend;
  logic signed [GW-1:0] win_left;
  logic signed [VW-1:0] win_center;
  logic signed [GW-1:0] ghost_right;
  logic                 cmd_end;

  // Active grid size, clamped to 1..GRID_DEPTH
  logic [CW-1:0] gp_ext;
  logic [CW-1:0] n_cw;
  logic [NW-1:0] n;
  logic          idx_ok;

  // RAM and unit hookup
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [VW-1:0]        ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [VW-1:0]        ram_rdata;
  logic                 u_issue;
  logic signed [GW-1:0] u_right;
  unit_stat_t           u_stat;
  logic [VW-1:0]        u_wdata;

  function automatic logic [VW-1:0] sat_in(input logic signed [31:0] v);
    logic signed [EW-1:0] x;
    logic [EW-VW:0]       top;
    x   = EW'(v);
    top = x[EW-1:VW-1];
    if ((&top) || !(|top)) begin
      return x[VW-1:0];
    end else if (x[EW-1]) begin
      return {1'b1, {(VW-1){1'b0}}};
    end else begin
      return {1'b0, {(VW-1){1'b1}}};
    end
  endfunction

  assign gp_ext = CW'(grid_points);
  assign n_cw   = (gp_ext == '0) ? CW'(1) :
                  (gp_ext > CW'(GRID_DEPTH)) ? CW'(GRID_DEPTH) : gp_ext;
  assign n      = NW'(n_cw);
  assign idx_ok = CW'(idx_q) < n_cw;
  assign busy   = (state != S_IDLE);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      bc_mode     <= BC_NEUMANN;
      left_term   <= '0;
      right_term  <= '0;
      coeff       <= '0;
      grid_points <= GRID_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_BC_MODE:     bc_mode     <= cfg_data[0];
        REG_LEFT_TERM:   left_term   <= $signed(cfg_data);
        REG_RIGHT_TERM:  right_term  <= $signed(cfg_data);
        REG_COEFF:       coeff       <= cfg_data[COEFF_W-1:0];
        REG_GRID_POINTS: grid_points <= cfg_data[GRID_W-1:0];
        default: ;
      endcase
    end
  end

  // Read address per state
  always_comb begin
    ram_raddr = '0;
    case (state)
      S_EXEC:  ram_raddr = AW'(idx_q);
      S_GH1:   ram_raddr = AW'(n - NW'(1));
      S_GH2:   ram_raddr = AW'(1);
      S_SWEEP: ram_raddr = rd_ptr[AW-1:0];
      default: ram_raddr = '0;
    endcase
  end

  // Write port: clear sweep, point write, or stencil result
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wr_ptr;
    ram_wdata = u_wdata;
    if (state == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_ptr;
      ram_wdata = '0;
    end else if (state == S_EXEC && func_q == FUNC_WRITE && idx_ok) begin
      ram_we    = 1'b1;
      ram_waddr = AW'(idx_q);
      ram_wdata = sat_in(val_q);
    end else if (u_stat.wr_valid) begin
      ram_we = 1'b1;
    end
  end

  // Feed the stencil unit; the last point takes the right ghost
  assign u_issue = (state == S_SWEEP);
  assign u_right = pend ? GW'($signed(ram_rdata)) : ghost_right;

  // Last cycle of a command: done follows on the next cycle
  always_comb begin
    cmd_end = 1'b0;
    case (state)
      S_EXEC:  cmd_end = !((func_q == FUNC_READ && idx_ok) ||
                           (func_q == FUNC_STEP && steps_left != '0));
      S_RWAIT: cmd_end = 1'b1;
      S_DRAIN: cmd_end = !u_stat.busy && (steps_left == STEPS_W'(1));
      default: cmd_end = 1'b0;
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_ptr <= '0;
      done    <= 1'b0;
    end else begin
      done <= cmd_end;
      if (state == S_GH2) begin
        wr_ptr <= '0;
      end else if (u_stat.wr_valid) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      unique case (state)
        S_CLEAR: begin
          clr_ptr <= clr_ptr + AW'(1);
          if (clr_ptr == AW'(GRID_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            func_q     <= func;
            idx_q      <= point_index;
            val_q      <= point_value;
            steps_left <= step_count;
            state      <= S_EXEC;
          end
        end
        S_EXEC: begin
          read_value <= '0;
          status     <= (func_q == FUNC_WRITE || func_q == FUNC_READ) && !idx_ok;
          case (func_q)
            FUNC_WRITE: begin
              state <= S_IDLE;
            end
            FUNC_READ: begin
              if (idx_ok) begin
                state <= S_RWAIT;
              end else begin
                state <= S_IDLE;
              end
            end
            FUNC_STEP: begin
              if (steps_left == '0) begin
                state <= S_IDLE;
              end else begin
                state <= S_GH0;
              end
            end
            default: begin
              state <= S_IDLE;
            end
          endcase
        end
        S_RWAIT: begin
          read_value <= 32'($signed(ram_rdata));
          status     <= 1'b0;
          state      <= S_IDLE;
        end
        S_GH0: begin
          state <= S_GH1;
        end
        // first point arrives: left ghost and window start
        S_GH1: begin
          win_center <= $signed(ram_rdata);
          if (bc_mode == BC_DIRICHLET) begin
            win_left <= GW'(left_term);
          end else begin
            win_left <= GW'($signed(ram_rdata)) - GW'(left_term);
          end
          state <= S_GH2;
        end
        // last point arrives: right ghost; read of point 1 goes out
        S_GH2: begin
          if (bc_mode == BC_DIRICHLET) begin
            ghost_right <= GW'(right_term);
          end else begin
            ghost_right <= GW'($signed(ram_rdata)) + GW'(right_term);
          end
          rd_ptr <= NW'(2);
          pend   <= (n > NW'(1));
          state  <= S_SWEEP;
        end
        // one point per cycle into the unit
        S_SWEEP: begin
          if (pend) begin
            win_left   <= GW'(win_center);
            win_center <= $signed(ram_rdata);
            pend       <= (rd_ptr < n);
            rd_ptr     <= rd_ptr + NW'(1);
          end else begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!u_stat.busy) begin
            if (steps_left == STEPS_W'(1)) begin
              state <= S_IDLE;
            end else begin
              steps_left <= steps_left - STEPS_W'(1);
              state      <= S_GH0;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  dsten_ram #(
    .WIDTH (VW),
    .DEPTH (GRID_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  dsten_unit #(
    .VALUE_WIDTH (VW)
  ) u_unit (
    .clk    (clk),
    .rst    (rst),
    .issue  (u_issue),
    .coeff  (coeff),
    .left   (win_left),
    .center (win_center),
    .right  (u_right),
    .stat   (u_stat),
    .wdata  (u_wdata)
  );

  // Stencil unit only holds points during a step
  a_unit_in_step: assert property (@(posedge clk) disable iff (rst)
    u_stat.busy |-> (state == S_SWEEP || state == S_DRAIN))
    else $error("stencil unit active outside a step");

  // Stencil results land inside the active grid
  a_write_in_grid: assert property (@(posedge clk) disable iff (rst)
    u_stat.wr_valid |-> (CW'(wr_ptr) < n_cw))
    else $error("stencil write beyond active grid");

  // One done pulse per command
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held for more than one cycle");

  // Accepted command makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("command accepted but block not busy");

  // Rejected access returns zero data
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status) |-> (read_value == '0))
    else $error("rejected access returned data");

endmodule

@@ design/dsten_ram.sv @@
`timescale 1ns / 1ps

module dsten_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/dsten_unit.sv @@
`timescale 1ns / 1ps

module dsten_unit
  import dsten_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                               clk,
  input  logic                                               rst,
  input  logic                                               issue,
  input  logic [COEFF_W-1:0]                                 coeff,
  input  logic signed [((VALUE_WIDTH > 32) ? VALUE_WIDTH : 32):0] left,
  input  logic signed [VALUE_WIDTH-1:0]                      center,
  input  logic signed [((VALUE_WIDTH > 32) ? VALUE_WIDTH : 32):0] right,
  output unit_stat_t                                         stat,
  output logic [VALUE_WIDTH-1:0]                             wdata
);

  localparam int VW = VALUE_WIDTH;
  localparam int GW = ((VW > 32) ? VW : 32) + 1;  // ghost / neighbor width
  localparam int LW = GW + 2;                     // laplacian
  localparam int PW = LW + COEFF_W + 1;           // product
  localparam int RW = PW + 1;                     // rounded product
  localparam int DW = RW - 16;                    // increment
  localparam int SW = DW + 1;                     // new value before clamp
  localparam logic signed [RW-1:0] RND_HALF = RW'(32768);

  logic                 v1, v2, v3, v4;
  logic signed [LW-1:0] lap;
  logic signed [PW-1:0] prod;
  logic signed [DW-1:0] inc;
  logic signed [VW-1:0] c1, c2, c3;
  logic signed [RW-1:0] rnd;
  logic signed [SW-1:0] sum;
  logic [SW-VW:0]       sum_top;

  // Valid pipe
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= issue;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  assign rnd     = RW'(prod) + RND_HALF;
  assign sum     = SW'(inc) + SW'(c3);
  assign sum_top = sum[SW-1:VW-1];

  // Laplacian, scale by r, round, add and clamp
  always_ff @(posedge clk) begin
    lap  <= LW'(left) + LW'(right) - (LW'(center) <<< 1);
    c1   <= center;
    prod <= PW'(lap) * PW'($signed({1'b0, coeff}));
    c2   <= c1;
    inc  <= DW'(rnd >>> 16);
    c3   <= c2;
    if ((&sum_top) || !(|sum_top)) begin
      wdata <= sum[VW-1:0];
    end else if (sum[SW-1]) begin
      wdata <= {1'b1, {(VW-1){1'b0}}};
    end else begin
      wdata <= {1'b0, {(VW-1){1'b1}}};
    end
  end

  assign stat.wr_valid = v4;
  assign stat.busy     = v1 | v2 | v3 | v4;

endmodule
